// ===== src/rtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to CMYK plane package
// Widths, pipeline depth and the divider lane type shared by the core, its
// divider stage and the channel interfaces.
// ----------------------------------------------------------------------------
package rtcp_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumW         = 2 * ChanW;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages    = ChanW / BitsPerStage;
  localparam int unsigned PipeDepth    = DivStages + 2;

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] low;
    logic [ChanW-1:0] quo;
  } div_lane_t;

endpackage

// ===== src/rtcp_if.sv =====
// ----------------------------------------------------------------------------
// RGB to CMYK plane channel interfaces
// Valid/ready channels for the incoming pixel and the outgoing plane bytes.
// ----------------------------------------------------------------------------
interface rtcp_pix_if import rtcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rtcp_cmyk_if import rtcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] cyan_out;
  logic [ChanW-1:0] magenta_out;
  logic [ChanW-1:0] yellow_out;
  logic [ChanW-1:0] black_out;

  modport source (output valid, cyan_out, magenta_out, yellow_out, black_out, input ready);
  modport sink (input valid, cyan_out, magenta_out, yellow_out, black_out, output ready);
endinterface

// ===== src/rtcp_div_stage.sv =====
// ----------------------------------------------------------------------------
// Restoring divider stage
// Retires two quotient bits of one lane and registers the partial result.
// ----------------------------------------------------------------------------
module rtcp_div_stage import rtcp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ChanW-1:0] divisor_i,
  input  div_lane_t        lane_i,
  output div_lane_t        lane_o
);

  div_lane_t      lane_d;
  div_lane_t      lane_q;
  logic [ChanW:0] trial;

  always_comb begin
    lane_d = lane_i;
    trial  = '0;
    for (int j = 0; j < BitsPerStage; j++) begin
      trial = {lane_d.rem, lane_d.low[ChanW-1]};
      if (trial >= {1'b0, divisor_i}) begin
        lane_d.rem = ChanW'(trial - {1'b0, divisor_i});
        lane_d.quo = {lane_d.quo[ChanW-2:0], 1'b1};
      end else begin
        lane_d.rem = trial[ChanW-1:0];
        lane_d.quo = {lane_d.quo[ChanW-2:0], 1'b0};
      end
      lane_d.low = {lane_d.low[ChanW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== src/rgb_to_cmyk_planes_core.sv =====
// ----------------------------------------------------------------------------
// RGB to CMYK plane converter
// Converts one RGB pixel per transaction into four inverted CMYK plane bytes.
// ----------------------------------------------------------------------------
// The core accepts one pixel every clock unless back-pressure has filled its
// pipeline. One stage finds the channel maximum, one forms the
// scaled numerators, and four stages of a restoring divider, one per lane,
// retire two quotient bits each. A stage holds its item while the next stage
// cannot take it, so back-pressure on the output loses and repeats nothing.
// A black pixel gives 255 on the cyan, magenta and yellow planes.
module rgb_to_cmyk_planes_core import rtcp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  rtcp_pix_if.sink   pix_i,
  rtcp_cmyk_if.source cmyk_o
);

  logic [PipeDepth-1:0] valid_q;
  logic [PipeDepth:0]   en;
  logic [ChanW-1:0]     m_q [PipeDepth];
  logic [ChanW-1:0]     m_d;
  logic [ChanW-1:0]     chan_in [NumChan];
  logic [ChanW-1:0]     chan_q [NumChan];
  div_lane_t            div_lane [DivStages+1][NumChan];
  logic [ChanW-1:0]     plane [NumChan];
  logic                 m_zero;

  assign chan_in[0] = pix_i.red;
  assign chan_in[1] = pix_i.green;
  assign chan_in[2] = pix_i.blue;

  always_comb begin
    en[PipeDepth] = cmyk_o.ready;
    for (int k = PipeDepth - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < PipeDepth; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    m_d = pix_i.red;
    if (pix_i.green > m_d) begin
      m_d = pix_i.green;
    end
    if (pix_i.blue > m_d) begin
      m_d = pix_i.blue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_q[0] <= m_d;
      for (int c = 0; c < NumChan; c++) begin
        chan_q[c] <= chan_in[c];
      end
    end
    for (int k = 1; k < PipeDepth; k++) begin
      if (en[k]) begin
        m_q[k] <= m_q[k-1];
      end
    end
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    logic [ChanW-1:0] diff;
    logic [NumW-1:0]  num;
    div_lane_t        lane1_q;

    assign diff = m_q[0] - chan_q[c];
    assign num  = {diff, {ChanW{1'b0}}} - {{ChanW{1'b0}}, diff};

    always_ff @(posedge clk_i) begin
      if (en[1]) begin
        lane1_q <= '{rem: num[NumW-1:ChanW], low: num[ChanW-1:0], quo: '0};
      end
    end

    assign div_lane[0][c] = lane1_q;

    for (genvar s = 0; s < DivStages; s++) begin : g_stage
      rtcp_div_stage u_div_stage (
        .clk_i     (clk_i),
        .en_i      (en[s+2]),
        .divisor_i (m_q[s+1]),
        .lane_i    (div_lane[s][c]),
        .lane_o    (div_lane[s+1][c])
      );
    end

    assign plane[c] = m_zero ? ChanMax : ~div_lane[DivStages][c].quo;
  end

  assign m_zero             = (m_q[PipeDepth-1] == '0);
  assign cmyk_o.valid       = valid_q[PipeDepth-1];
  assign cmyk_o.cyan_out    = plane[0];
  assign cmyk_o.magenta_out = plane[1];
  assign cmyk_o.yellow_out  = plane[2];
  assign cmyk_o.black_out   = m_q[PipeDepth-1];

  // An accepted pixel always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> valid_q[0])
    else $error("accepted pixel did not enter the pipeline");

  // A stalled second-to-last stage keeps its item.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[PipeDepth-2] && !en[PipeDepth-2] |=> valid_q[PipeDepth-2])
    else $error("stalled stage dropped its item");

  // The channel equal to the maximum always gives a full plane byte.
  a_full_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmyk_o.valid |-> (cmyk_o.cyan_out == ChanMax) || (cmyk_o.magenta_out == ChanMax)
                     || (cmyk_o.yellow_out == ChanMax))
    else $error("no plane byte at full scale");

  // The final remainder of every lane is below a nonzero divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmyk_o.valid && !m_zero |-> (div_lane[DivStages][0].rem < m_q[PipeDepth-1])
                                && (div_lane[DivStages][1].rem < m_q[PipeDepth-1])
                                && (div_lane[DivStages][2].rem < m_q[PipeDepth-1]))
    else $error("divider remainder out of range");

endmodule
